[rtl/core/drp_pkg.sv]
// ----------------------------------------------------------------------------
// drp_pkg: shared types and constants of the DHCP reply parser
// Command, message type, option and result codes, and the structs passed
// between the parser, the lease store and the top level.
// ----------------------------------------------------------------------------
package drp_pkg;

	localparam logic [7:0] HDR_LEN = 8'd240;

	// input commands
	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// option codes
	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_MASK     = 8'd1;
	localparam logic [7:0] OPT_ROUTER   = 8'd3;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_END      = 8'd255;

	// DHCP message types
	localparam logic [7:0] MT_OFFER = 8'd2;
	localparam logic [7:0] MT_ACK   = 8'd5;
	localparam logic [7:0] MT_NAK   = 8'd6;

	// reported message kind
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_OFFER = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;
	localparam logic [1:0] KIND_NAK   = 2'd3;

	// summary of a message as it stands after its current byte
	typedef struct packed {
		logic        accepted;
		logic [7:0]  found_type;
		logic [31:0] found_mask;
		logic [31:0] found_router;
		logic [31:0] found_server_id;
		logic        server_id_given;
		logic [31:0] your_addr;
		logic [31:0] server_addr;
	} msg_sum_t;

	// events applied to the lease store
	typedef struct packed {
		logic done;   // last byte of a message processed
		logic clear;  // clear the sticky flags
	} lease_ev_t;

	typedef struct packed {
		logic        msg_accepted;
		logic [1:0]  msg_kind;
		logic        offer_seen;
		logic        ack_seen;
		logic        nak_seen;
		logic [31:0] lease_ip;
		logic [31:0] lease_server;
		logic [31:0] lease_mask;
		logic [31:0] lease_gateway;
	} result_t;

	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] val;
		case (idx)
			2'd0: val = 8'd99;
			2'd1: val = 8'd130;
			2'd2: val = 8'd83;
			default: val = 8'd99;
		endcase
		return val;
	endfunction

endpackage

[rtl/core/drp_if.sv]
// ----------------------------------------------------------------------------
// drp_if: channel interfaces of the DHCP reply parser
// Byte input channel, result channel and expected_xid write channel.
// ----------------------------------------------------------------------------
interface drp_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;
	logic       is_last;

	modport source (output valid, output command, output rx_byte, output is_last,
		input ready);
	modport sink (input valid, input command, input rx_byte, input is_last,
		output ready);
endinterface

interface drp_out_if;
	logic        valid;
	logic        ready;
	logic        msg_accepted;
	logic [1:0]  msg_kind;
	logic        offer_seen;
	logic        ack_seen;
	logic        nak_seen;
	logic [31:0] lease_ip;
	logic [31:0] lease_server;
	logic [31:0] lease_mask;
	logic [31:0] lease_gateway;

	modport source (output valid, output msg_accepted, output msg_kind,
		output offer_seen, output ack_seen, output nak_seen, output lease_ip,
		output lease_server, output lease_mask, output lease_gateway, input ready);
	modport sink (input valid, input msg_accepted, input msg_kind,
		input offer_seen, input ack_seen, input nak_seen, input lease_ip,
		input lease_server, input lease_mask, input lease_gateway, output ready);
endinterface

interface drp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] expected_xid;

	modport source (output valid, output expected_xid, input ready);
	modport sink (input valid, input expected_xid, output ready);
endinterface

[rtl/core/drp_parse.sv]
// ----------------------------------------------------------------------------
// drp_parse: header check and option walk
// Tracks one message byte by byte: header position, xid and cookie checks,
// yiaddr/siaddr capture and the TLV option walk. Gives the message summary
// as it stands after the current byte.
// ----------------------------------------------------------------------------
module drp_parse import drp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic        is_last,
	input  logic [31:0] expected_xid,
	output msg_sum_t    msg
);

	typedef enum logic [1:0] {
		PH_CODE  = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  pos_q, pos_n;
	logic        hdr_ok_q, hdr_ok_n;
	logic [31:0] yi_q, yi_n, si_q, si_n;
	logic [7:0]  type_q, type_n, len_q, len_n, cnt_q, cnt_n;
	logic [31:0] acc_q, acc_n;
	logic        stopped_q, stopped_n;
	logic [7:0]  ftype_q, ftype_n;
	logic [31:0] fmask_q, fmask_n, frouter_q, frouter_n, fsid_q, fsid_n;
	logic        sid_given_q, sid_given_n;

	always_comb begin
		pos_n       = pos_q;
		hdr_ok_n    = hdr_ok_q;
		yi_n        = yi_q;
		si_n        = si_q;
		phase_n     = phase_q;
		type_n      = type_q;
		len_n       = len_q;
		cnt_n       = cnt_q;
		acc_n       = acc_q;
		stopped_n   = stopped_q;
		ftype_n     = ftype_q;
		fmask_n     = fmask_q;
		frouter_n   = frouter_q;
		fsid_n      = fsid_q;
		sid_given_n = sid_given_q;
		if (step) begin
			if (pos_q < HDR_LEN) begin
				pos_n = pos_q + 8'd1;
				if (pos_q >= 8'd4 && pos_q <= 8'd7) begin
					if (rx_byte != expected_xid[{pos_q[1:0], 3'b000} +: 8])
						hdr_ok_n = 1'b0;
				end else if (pos_q >= 8'd16 && pos_q <= 8'd19) begin
					yi_n = {yi_q[23:0], rx_byte};
				end else if (pos_q >= 8'd20 && pos_q <= 8'd23) begin
					si_n = {si_q[23:0], rx_byte};
				end else if (pos_q >= 8'd236 && pos_q <= 8'd239) begin
					if (rx_byte != cookie_byte(pos_q[1:0]))
						hdr_ok_n = 1'b0;
				end
			end else if (!stopped_q) begin
				case (phase_q)
					PH_LEN: begin
						// zero-length option commits nothing
						len_n   = rx_byte;
						cnt_n   = 8'd0;
						acc_n   = 32'd0;
						phase_n = (rx_byte == 8'd0) ? PH_CODE : PH_VALUE;
					end
					PH_VALUE: begin
						if (cnt_q < 8'd4)
							acc_n = {acc_q[23:0], rx_byte};
						cnt_n = cnt_q + 8'd1;
						if (cnt_n >= len_q) begin
							phase_n = PH_CODE;
							case (type_q)
								OPT_MSG_TYPE: begin
									// first value byte, wherever it landed
									case (len_q)
										8'd1: ftype_n = acc_n[7:0];
										8'd2: ftype_n = acc_n[15:8];
										8'd3: ftype_n = acc_n[23:16];
										default: ftype_n = acc_n[31:24];
									endcase
								end
								OPT_MASK: begin
									if (len_q >= 8'd4) fmask_n = acc_n;
								end
								OPT_ROUTER: begin
									if (len_q >= 8'd4) frouter_n = acc_n;
								end
								OPT_SERVER: begin
									if (len_q >= 8'd4) begin
										fsid_n      = acc_n;
										sid_given_n = 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
					default: begin
						if (rx_byte == OPT_END) begin
							stopped_n = 1'b1;
						end else if (rx_byte != OPT_PAD) begin
							type_n  = rx_byte;
							phase_n = PH_LEN;
						end else begin
							phase_n = PH_CODE;
						end
					end
				endcase
			end
		end
	end

	assign msg.accepted        = hdr_ok_n && (pos_n == HDR_LEN);
	assign msg.found_type      = ftype_n;
	assign msg.found_mask      = fmask_n;
	assign msg.found_router    = frouter_n;
	assign msg.found_server_id = fsid_n;
	assign msg.server_id_given = sid_given_n;
	assign msg.your_addr       = yi_n;
	assign msg.server_addr     = si_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CODE;
			pos_q       <= 8'd0;
			hdr_ok_q    <= 1'b1;
			yi_q        <= 32'd0;
			si_q        <= 32'd0;
			type_q      <= 8'd0;
			len_q       <= 8'd0;
			cnt_q       <= 8'd0;
			acc_q       <= 32'd0;
			stopped_q   <= 1'b0;
			ftype_q     <= 8'd0;
			fmask_q     <= 32'd0;
			frouter_q   <= 32'd0;
			fsid_q      <= 32'd0;
			sid_given_q <= 1'b0;
		end else if (step && is_last) begin
			// message done: back to the start state
			phase_q     <= PH_CODE;
			pos_q       <= 8'd0;
			hdr_ok_q    <= 1'b1;
			yi_q        <= 32'd0;
			si_q        <= 32'd0;
			type_q      <= 8'd0;
			len_q       <= 8'd0;
			cnt_q       <= 8'd0;
			acc_q       <= 32'd0;
			stopped_q   <= 1'b0;
			ftype_q     <= 8'd0;
			fmask_q     <= 32'd0;
			frouter_q   <= 32'd0;
			fsid_q      <= 32'd0;
			sid_given_q <= 1'b0;
		end else begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			hdr_ok_q    <= hdr_ok_n;
			yi_q        <= yi_n;
			si_q        <= si_n;
			type_q      <= type_n;
			len_q       <= len_n;
			cnt_q       <= cnt_n;
			acc_q       <= acc_n;
			stopped_q   <= stopped_n;
			ftype_q     <= ftype_n;
			fmask_q     <= fmask_n;
			frouter_q   <= frouter_n;
			fsid_q      <= fsid_n;
			sid_given_q <= sid_given_n;
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= HDR_LEN)
		else $error("header position past saturation");

	a_walk_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q || phase_q != PH_CODE) |-> pos_q == HDR_LEN)
		else $error("option walk active inside header");

	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_last |=> pos_q == 8'd0 && hdr_ok_q && !stopped_q)
		else $error("message state not reset after last byte");

endmodule

[rtl/core/drp_lease.sv]
// ----------------------------------------------------------------------------
// drp_lease: lease store and result register
// Applies an accepted offer, ack or nak to the stored lease and sticky
// flags, and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module drp_lease import drp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lease_ev_t ev,
	input  msg_sum_t  msg,
	input  logic      out_ready,
	output logic      out_valid,
	output result_t   res
);

	logic [31:0] ip_q, ip_n, srv_q, srv_n, mask_q, mask_n, rtr_q, rtr_n;
	logic        offer_q, offer_n, ack_q, ack_n, nak_q, nak_n;
	logic [1:0]  kind;
	logic        out_valid_q;
	result_t     res_q;

	always_comb begin
		ip_n    = ip_q;
		srv_n   = srv_q;
		mask_n  = mask_q;
		rtr_n   = rtr_q;
		offer_n = offer_q;
		ack_n   = ack_q;
		nak_n   = nak_q;
		kind    = KIND_NONE;
		if (ev.clear) begin
			offer_n = 1'b0;
			ack_n   = 1'b0;
			nak_n   = 1'b0;
		end
		if (ev.done && msg.accepted) begin
			case (msg.found_type)
				MT_OFFER: begin
					kind    = KIND_OFFER;
					ip_n    = msg.your_addr;
					srv_n   = msg.server_id_given ? msg.found_server_id : msg.server_addr;
					mask_n  = msg.found_mask;
					rtr_n   = msg.found_router;
					offer_n = 1'b1;
				end
				MT_ACK: begin
					kind  = KIND_ACK;
					ip_n  = msg.your_addr;
					if (msg.found_mask != 32'd0) mask_n = msg.found_mask;
					if (msg.found_router != 32'd0) rtr_n = msg.found_router;
					ack_n = 1'b1;
				end
				MT_NAK: begin
					kind  = KIND_NAK;
					nak_n = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q        <= 32'd0;
			srv_q       <= 32'd0;
			mask_q      <= 32'd0;
			rtr_q       <= 32'd0;
			offer_q     <= 1'b0;
			ack_q       <= 1'b0;
			nak_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ip_q    <= ip_n;
			srv_q   <= srv_n;
			mask_q  <= mask_n;
			rtr_q   <= rtr_n;
			offer_q <= offer_n;
			ack_q   <= ack_n;
			nak_q   <= nak_n;
			if (ev.done)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.done) begin
			res_q.msg_accepted  <= msg.accepted;
			res_q.msg_kind      <= kind;
			res_q.offer_seen    <= offer_n;
			res_q.ack_seen      <= ack_n;
			res_q.nak_seen      <= nak_n;
			res_q.lease_ip      <= ip_n;
			res_q.lease_server  <= srv_n;
			res_q.lease_mask    <= mask_n;
			res_q.lease_gateway <= rtr_n;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ev.done |-> !out_valid_q || out_ready)
		else $error("result overwritten before it was taken");

	a_reject_kind: assert property (@(posedge clk) disable iff (!arst_n)
		ev.done && !msg.accepted |=> res_q.msg_kind == KIND_NONE)
		else $error("rejected message reported a kind");

	a_kind_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.msg_kind == KIND_OFFER |-> res_q.offer_seen)
		else $error("offer reported without offer flag");

endmodule

[rtl/core/dhcp_reply_parser_top.sv]
// ----------------------------------------------------------------------------
// dhcp_reply_parser_top: DHCP client reply parser
// Byte-serial parser of DHCP replies with lease store and sticky flags.
// ----------------------------------------------------------------------------
// Takes one item per clock: a message byte with its last-byte mark, or a
// clear-flags command. An accepted item is held in the input register, where
// header check, option walk and lease update are done in a single pass; the
// last byte of a message loads the result register, so res.valid rises as
// that last byte leaves the input register. The input only stalls when a
// result is waiting in the result register, is not taken, and the item in
// the input register is a last byte. expected_xid is written through cfg,
// always ready, by the user only while no message is in flight (unenforced).
module dhcp_reply_parser_top import drp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	drp_in_if.sink    rx,
	drp_out_if.source res,
	drp_cfg_if.sink   cfg
);

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] xid_q;
	logic        produce;
	logic        adv;
	logic        out_valid;
	lease_ev_t   ev;
	msg_sum_t    msg;
	result_t     res_data;

	assign produce  = valid_s1 && (cmd_s1 == CMD_BYTE) && last_s1;
	assign adv      = valid_s1 && (!produce || !out_valid || res.ready);
	assign rx.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			xid_q    <= 32'd0;
		end else begin
			if (rx.valid && rx.ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (cfg.valid)
				xid_q <= cfg.expected_xid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			cmd_s1  <= rx.command;
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.is_last;
		end
	end

	assign ev.done  = adv && produce;
	assign ev.clear = adv && (cmd_s1 == CMD_CLEAR);

	drp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv && (cmd_s1 == CMD_BYTE)),
		.rx_byte      (byte_s1),
		.is_last      (last_s1),
		.expected_xid (xid_q),
		.msg          (msg)
	);

	drp_lease u_lease (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (ev),
		.msg       (msg),
		.out_ready (res.ready),
		.out_valid (out_valid),
		.res       (res_data)
	);

	assign res.valid         = out_valid;
	assign res.msg_accepted  = res_data.msg_accepted;
	assign res.msg_kind      = res_data.msg_kind;
	assign res.offer_seen    = res_data.offer_seen;
	assign res.ack_seen      = res_data.ack_seen;
	assign res.nak_seen      = res_data.nak_seen;
	assign res.lease_ip      = res_data.lease_ip;
	assign res.lease_server  = res_data.lease_server;
	assign res.lease_mask    = res_data.lease_mask;
	assign res.lease_gateway = res_data.lease_gateway;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input item lost or changed");

endmodule

[test/dhcp_reply_parser_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhcp_reply_parser_top_tb: self-checking bench of the DHCP reply parser
// Walks a short list of directed replies and commands, then random replies,
// mostly well-formed with random options plus noise, under random gaps on
// both sides and one long result hold-off. Each result is checked field by
// field against a lease predictor run on every accepted item.
// ----------------------------------------------------------------------------
module dhcp_reply_parser_top_tb;
	import drp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MIN_ITEMS   = 600;
	localparam int unsigned MIN_RESULTS = 48;
	localparam logic [31:0] MAGIC = {8'd99, 8'd130, 8'd83, 8'd99};

	typedef enum logic [1:0] {WAIT_CODE, WAIT_LEN, IN_VALUE} opt_phase_e;
	typedef enum logic [1:0] {ROW_REPLY, ROW_CLEAR, ROW_XID} plan_op_e;
	typedef enum logic [3:0] {
		RC_PLAIN, RC_NO_SERVER, RC_BARE, RC_NO_TYPE, RC_BAD_XID, RC_BAD_COOKIE,
		RC_SHORT_HDR, RC_ONE_BYTE, RC_ODD_LENGTHS, RC_TRUNCATED, RC_END_JUNK,
		RC_REPEAT, RC_PADS, RC_CLEAR_MID
	} reply_case_e;

	typedef struct packed {
		logic [31:0] yi;
		logic [31:0] si;
		logic        xid_bad;
		logic        cookie_bad;
		logic [7:0]  cut;        // 0 keeps the whole reply
		logic        has_type;
		logic [7:0]  mtype;
		logic [7:0]  type_len;
		logic        has_mask;
		logic [31:0] mask;
		logic [7:0]  mask_len;
		logic        has_router;
		logic [31:0] router;
		logic [7:0]  router_len;
		logic        has_server;
		logic [31:0] server;
		logic [7:0]  server_len;
		logic        pads;
		logic        end_mark;
		logic        junk_after;
		logic        truncate;
		logic        repeat_mask;
		logic        clear_mid;
	} reply_desc_t;

	typedef struct packed {
		plan_op_e    op;
		reply_case_e rc;
		logic [7:0]  mtype;
		logic [31:0] xid;
		logic        typed;
		result_t     want;
	} plan_row_t;

	// typed rows come before any lease is stored, so all-zero results
	plan_row_t directed_plan [$] = '{
		'{ROW_REPLY, RC_ONE_BYTE,    8'd0,     32'd0,        1'b1, '0},
		'{ROW_REPLY, RC_SHORT_HDR,   MT_OFFER, 32'd0,        1'b1, '0},
		'{ROW_REPLY, RC_BAD_XID,     MT_OFFER, 32'd0,        1'b1, '0},
		'{ROW_REPLY, RC_BAD_COOKIE,  MT_ACK,   32'd0,        1'b1, '0},
		'{ROW_CLEAR, RC_PLAIN,       8'd0,     32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_PLAIN,       MT_OFFER, 32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_NO_SERVER,   MT_OFFER, 32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_BARE,        MT_ACK,   32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_PLAIN,       MT_ACK,   32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_PLAIN,       MT_NAK,   32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_PLAIN,       8'd1,     32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_NO_TYPE,     8'd0,     32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_ODD_LENGTHS, MT_OFFER, 32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_TRUNCATED,   MT_ACK,   32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_END_JUNK,    MT_OFFER, 32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_REPEAT,      MT_ACK,   32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_PADS,        MT_NAK,   32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_CLEAR_MID,   MT_OFFER, 32'd0,        1'b0, '0},
		'{ROW_XID,   RC_PLAIN,       8'd0,     32'hFFFFFFFF, 1'b0, '0},
		'{ROW_REPLY, RC_PLAIN,       MT_OFFER, 32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_BAD_XID,     MT_ACK,   32'd0,        1'b0, '0},
		'{ROW_CLEAR, RC_PLAIN,       8'd0,     32'd0,        1'b0, '0},
		'{ROW_REPLY, RC_PLAIN,       MT_ACK,   32'd0,        1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	drp_in_if  in_ch ();
	drp_out_if out_ch ();
	drp_cfg_if xid_ch ();

	dhcp_reply_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (in_ch),
		.res    (out_ch),
		.cfg    (xid_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: configuration, message in progress, stored lease
	logic [31:0] xid_cfg = '0;
	int unsigned m_pos;
	logic        m_hdr_ok;
	logic [31:0] m_yiaddr, m_siaddr;
	opt_phase_e  m_phase;
	logic [7:0]  m_opt_code;
	int unsigned m_opt_len, m_opt_cnt;
	logic [31:0] m_accum;
	logic        m_walk_done;
	logic [7:0]  m_type;
	logic [31:0] m_mask, m_router, m_srv_id;
	logic        m_srv_given;
	logic [31:0] lease_ip = '0, lease_server = '0, lease_mask = '0, lease_gw = '0;
	logic        seen_offer = 1'b0, seen_ack = 1'b0, seen_nak = 1'b0;

	result_t     pending_results [$];
	logic [7:0]  reply_buf [$];
	result_t     head;
	result_t     typed_want;
	logic        typed_pending = 1'b0;
	logic        gaps_on = 1'b1;
	logic        hold_req = 1'b0;
	logic        failed = 1'b0;
	int unsigned sent_items = 0;
	int unsigned results_made = 0;
	int unsigned cycle_count = 0;

	function automatic void restart_message();
		m_pos = 0;
		m_hdr_ok = 1'b1;
		m_yiaddr = '0;
		m_siaddr = '0;
		m_phase = WAIT_CODE;
		m_opt_code = '0;
		m_opt_len = 0;
		m_opt_cnt = 0;
		m_accum = '0;
		m_walk_done = 1'b0;
		m_type = '0;
		m_mask = '0;
		m_router = '0;
		m_srv_id = '0;
		m_srv_given = 1'b0;
	endfunction

	function automatic void close_option();
		int unsigned n;
		n = (m_opt_len < 4) ? m_opt_len : 4;
		if (m_opt_code == OPT_MSG_TYPE && m_opt_len >= 1) begin
			m_type = 8'(m_accum >> (8 * (n - 1)));
		end else if (m_opt_code == OPT_MASK && m_opt_len >= 4) begin
			m_mask = m_accum;
		end else if (m_opt_code == OPT_ROUTER && m_opt_len >= 4) begin
			m_router = m_accum;
		end else if (m_opt_code == OPT_SERVER && m_opt_len >= 4) begin
			m_srv_id = m_accum;
			m_srv_given = 1'b1;
		end
	endfunction

	function automatic void take_header_byte(input int unsigned p, input logic [7:0] b);
		if (p >= 4 && p <= 7) begin
			if (b != xid_cfg[8 * (p - 4) +: 8]) m_hdr_ok = 1'b0;
		end else if (p >= 16 && p <= 19) begin
			m_yiaddr = {m_yiaddr[23:0], b};
		end else if (p >= 20 && p <= 23) begin
			m_siaddr = {m_siaddr[23:0], b};
		end else if (p >= 236 && p <= 239) begin
			if (b != MAGIC[31 - 8 * (p - 236) -: 8]) m_hdr_ok = 1'b0;
		end
	endfunction

	function automatic void walk_option_byte(input logic [7:0] b);
		if (!m_walk_done) begin
			case (m_phase)
				WAIT_LEN: begin
					m_opt_len = b;
					m_opt_cnt = 0;
					m_accum = '0;
					if (b == 8'd0) begin
						close_option();
						m_phase = WAIT_CODE;
					end else begin
						m_phase = IN_VALUE;
					end
				end
				IN_VALUE: begin
					// only the first four value bytes are kept
					if (m_opt_cnt < 4) m_accum = {m_accum[23:0], b};
					m_opt_cnt++;
					if (m_opt_cnt >= m_opt_len) begin
						close_option();
						m_phase = WAIT_CODE;
					end
				end
				default: begin
					if (b == OPT_END) begin
						m_walk_done = 1'b1;
					end else if (b != OPT_PAD) begin
						m_opt_code = b;
						m_phase = WAIT_LEN;
					end
				end
			endcase
		end
	endfunction

	// returns 1 when the item closes a message, with the lease report in r
	function automatic logic predict_reply(input logic cmd, input logic [7:0] b,
		input logic last, output result_t r);
		logic       ok;
		logic [1:0] kind;
		r = '0;
		if (cmd == CMD_CLEAR) begin
			seen_offer = 1'b0;
			seen_ack = 1'b0;
			seen_nak = 1'b0;
			return 1'b0;
		end
		if (m_pos < HDR_LEN) begin
			take_header_byte(m_pos, b);
			m_pos++;
		end else begin
			walk_option_byte(b);
		end
		if (!last) return 1'b0;
		ok = m_hdr_ok && (m_pos >= HDR_LEN);
		kind = KIND_NONE;
		if (ok) begin
			case (m_type)
				MT_OFFER: begin
					kind = KIND_OFFER;
					lease_ip = m_yiaddr;
					lease_server = m_srv_given ? m_srv_id : m_siaddr;
					lease_mask = m_mask;
					lease_gw = m_router;
					seen_offer = 1'b1;
				end
				MT_ACK: begin
					kind = KIND_ACK;
					lease_ip = m_yiaddr;
					if (m_mask != '0) lease_mask = m_mask;
					if (m_router != '0) lease_gw = m_router;
					seen_ack = 1'b1;
				end
				MT_NAK: begin
					kind = KIND_NAK;
					seen_nak = 1'b1;
				end
				default: kind = KIND_NONE;
			endcase
		end
		r.msg_accepted = ok;
		r.msg_kind = kind;
		r.offer_seen = seen_offer;
		r.ack_seen = seen_ack;
		r.nak_seen = seen_nak;
		r.lease_ip = lease_ip;
		r.lease_server = lease_server;
		r.lease_mask = lease_mask;
		r.lease_gateway = lease_gw;
		restart_message();
		return 1'b1;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic reply_desc_t shape_reply(input reply_case_e rc, input logic [7:0] mt);
		reply_desc_t d;
		d = '0;
		d.yi = pick_word();
		d.si = pick_word();
		d.has_type = 1'b1;
		d.mtype = mt;
		d.type_len = 8'd1;
		d.has_mask = 1'b1;
		d.mask = pick_word();
		d.mask_len = 8'd4;
		d.has_router = 1'b1;
		d.router = pick_word();
		d.router_len = 8'd4;
		d.has_server = 1'b1;
		d.server = pick_word();
		d.server_len = 8'd4;
		case (rc)
			RC_NO_SERVER: d.has_server = 1'b0;
			RC_BARE: begin
				d.has_mask = 1'b0;
				d.has_router = 1'b0;
				d.has_server = 1'b0;
			end
			RC_NO_TYPE: d.has_type = 1'b0;
			RC_BAD_XID: d.xid_bad = 1'b1;
			RC_BAD_COOKIE: d.cookie_bad = 1'b1;
			RC_SHORT_HDR: d.cut = 8'd239;
			RC_ONE_BYTE: d.cut = 8'd1;
			RC_ODD_LENGTHS: begin
				d.type_len = 8'd3;
				d.mask_len = 8'd2;
				d.router_len = 8'd6;
				d.server_len = 8'd0;
			end
			RC_TRUNCATED: d.truncate = 1'b1;
			RC_END_JUNK: begin
				d.end_mark = 1'b1;
				d.junk_after = 1'b1;
			end
			RC_REPEAT: d.repeat_mask = 1'b1;
			RC_PADS: begin
				d.pads = 1'b1;
				d.end_mark = 1'b1;
			end
			RC_CLEAR_MID: d.clear_mid = 1'b1;
			default: ;
		endcase
		return d;
	endfunction

	// value goes out big-endian; bytes past the fourth are filler
	function automatic void put_option(input logic [7:0] code, input logic [7:0] len,
		input logic [31:0] val);
		reply_buf.push_back(code);
		reply_buf.push_back(len);
		for (int i = 0; i < len; i++)
			reply_buf.push_back(i < 4 ? val[31 - 8 * i -: 8] : 8'($urandom));
	endfunction

	function automatic void fill_reply(input reply_desc_t d);
		int unsigned k;
		reply_buf.delete();
		for (int i = 0; i < 240; i++) reply_buf.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) begin
			reply_buf[4 + i] = xid_cfg[8 * i +: 8];
			reply_buf[16 + i] = d.yi[31 - 8 * i -: 8];
			reply_buf[20 + i] = d.si[31 - 8 * i -: 8];
			reply_buf[236 + i] = MAGIC[31 - 8 * i -: 8];
		end
		if (d.xid_bad) begin
			k = $urandom_range(4, 7);
			reply_buf[k] = reply_buf[k] ^ 8'(1 << $urandom_range(0, 7));
		end
		if (d.cookie_bad) begin
			k = $urandom_range(236, 239);
			reply_buf[k] = reply_buf[k] ^ 8'(1 << $urandom_range(0, 7));
		end
		if (d.pads) begin
			repeat ($urandom_range(1, 3)) reply_buf.push_back(OPT_PAD);
			put_option(8'($urandom_range(2, 252)), 8'($urandom_range(0, 5)), $urandom);
			put_option(OPT_ROUTER, 8'd0, '0);
		end
		if (d.repeat_mask) put_option(OPT_MASK, 8'd4, $urandom);
		if (d.has_type) put_option(OPT_MSG_TYPE, d.type_len, {d.mtype, 24'($urandom)});
		if (d.has_mask) put_option(OPT_MASK, d.mask_len, d.mask);
		if (d.pads) repeat ($urandom_range(1, 2)) reply_buf.push_back(OPT_PAD);
		if (d.has_router) put_option(OPT_ROUTER, d.router_len, d.router);
		if (d.has_server) put_option(OPT_SERVER, d.server_len, d.server);
		if (d.end_mark) begin
			reply_buf.push_back(OPT_END);
			// anything past the end mark must be ignored
			if (d.junk_after) put_option(OPT_MSG_TYPE, 8'd1, {MT_NAK, 24'd0});
		end
		if (d.truncate) begin
			reply_buf.push_back(OPT_SERVER);
			reply_buf.push_back(8'($urandom_range(4, 20)));
			reply_buf.push_back(8'($urandom));
		end
		if (d.cut != 0)
			while (reply_buf.size() > d.cut) void'(reply_buf.pop_back());
	endfunction

	task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
		result_t r;
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.rx_byte <= b;
		in_ch.is_last <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_items++;
		if (predict_reply(cmd, b, last, r)) begin
			if (typed_pending) begin
				r = typed_want;
				typed_pending = 1'b0;
			end
			pending_results.push_back(r);
			results_made++;
		end
	endtask

	task automatic send_reply(input logic clear_mid);
		int unsigned at;
		at = clear_mid ? $urandom_range(0, reply_buf.size() - 1) : reply_buf.size();
		for (int i = 0; i < reply_buf.size(); i++) begin
			if (i == at) send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
			send_item(CMD_BYTE, reply_buf[i], i == reply_buf.size() - 1);
		end
	endtask

	task automatic wait_quiet(input int unsigned tail);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_xid(input logic [31:0] v);
		wait_quiet(4);
		@(negedge clk);
		xid_ch.valid <= 1'b1;
		xid_ch.expected_xid <= v;
		do @(posedge clk); while (xid_ch.ready !== 1'b1);
		xid_cfg = v;
		@(negedge clk);
		xid_ch.valid <= 1'b0;
	endtask

	task automatic send_random_message();
		reply_desc_t d;
		logic [7:0] mt;
		int unsigned n;
		if ($urandom_range(0, 5) == 0) begin
			// noise: short junk or header-sized junk
			reply_buf.delete();
			n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(240, 280);
			repeat (n) reply_buf.push_back(8'($urandom));
			send_reply($urandom_range(0, 9) == 0);
		end else begin
			case ($urandom_range(0, 3))
				0: mt = MT_OFFER;
				1: mt = MT_ACK;
				2: mt = MT_NAK;
				default: mt = 8'($urandom);
			endcase
			d = shape_reply(RC_PLAIN, mt);
			d.has_type = ($urandom_range(0, 9) != 0);
			d.has_mask = ($urandom_range(0, 3) != 0);
			d.has_router = ($urandom_range(0, 3) != 0);
			d.has_server = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) d.type_len = 8'($urandom_range(0, 5));
			if ($urandom_range(0, 7) == 0) d.mask_len = 8'($urandom_range(0, 7));
			if ($urandom_range(0, 7) == 0) d.router_len = 8'($urandom_range(0, 7));
			if ($urandom_range(0, 7) == 0) d.server_len = 8'($urandom_range(0, 7));
			d.xid_bad = ($urandom_range(0, 11) == 0);
			d.cookie_bad = ($urandom_range(0, 11) == 0);
			if ($urandom_range(0, 15) == 0) d.cut = 8'($urandom_range(1, 239));
			d.pads = ($urandom_range(0, 2) == 0);
			d.end_mark = ($urandom_range(0, 1) == 0);
			d.junk_after = ($urandom_range(0, 2) == 0);
			d.truncate = ($urandom_range(0, 7) == 0);
			d.repeat_mask = ($urandom_range(0, 7) == 0);
			d.clear_mid = ($urandom_range(0, 9) == 0);
			fill_reply(d);
			send_reply(d.clear_mid);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual kind %0d",
					$time, out_ch.msg_kind);
				failed = 1'b1;
			end else begin
				head = pending_results.pop_front();
				check_field("msg_accepted", head.msg_accepted, out_ch.msg_accepted);
				check_field("msg_kind", head.msg_kind, out_ch.msg_kind);
				check_field("offer_seen", head.offer_seen, out_ch.offer_seen);
				check_field("ack_seen", head.ack_seen, out_ch.ack_seen);
				check_field("nak_seen", head.nak_seen, out_ch.nak_seen);
				check_field("lease_ip", head.lease_ip, out_ch.lease_ip);
				check_field("lease_server", head.lease_server, out_ch.lease_server);
				check_field("lease_mask", head.lease_mask, out_ch.lease_mask);
				check_field("lease_gateway", head.lease_gateway, out_ch.lease_gateway);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		hold_left = 0;
		stall_left = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (gaps_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
			end
		end
	end

	initial begin
		plan_row_t row;
		reply_desc_t d;
		int unsigned msg_no;
		int unsigned cfg_no;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_BYTE;
		in_ch.rx_byte = '0;
		in_ch.is_last = 1'b0;
		xid_ch.valid = 1'b0;
		xid_ch.expected_xid = '0;
		restart_message();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			case (row.op)
				ROW_XID: write_xid(row.xid);
				ROW_CLEAR: send_item(CMD_CLEAR, 8'hFF, 1'b1);
				default: begin
					typed_pending = row.typed;
					typed_want = row.want;
					d = shape_reply(row.rc, row.mtype);
					fill_reply(d);
					send_reply(d.clear_mid);
				end
			endcase
		end

		msg_no = 0;
		cfg_no = 0;
		while (sent_items < MIN_ITEMS || results_made < MIN_RESULTS) begin
			if (msg_no % 10 == 9) begin
				case (cfg_no % 3)
					0: write_xid($urandom);
					1: write_xid('0);
					default: write_xid('1);
				endcase
				cfg_no++;
			end
			if (msg_no % 7 == 0) gaps_on = ($urandom_range(0, 3) != 0);
			if (msg_no == 20) begin
				// results held back while tiny messages keep coming
				hold_req = 1'b1;
				repeat (40) begin
					reply_buf.delete();
					repeat ($urandom_range(1, 2)) reply_buf.push_back(8'($urandom));
					send_reply(1'b0);
				end
			end else begin
				send_random_message();
			end
			msg_no++;
		end

		gaps_on = 1'b0;
		repeat (6) send_random_message();
		wait_quiet(8);

		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
